// ----- hw/rtl/aligned_read_filter_extend_stats_top_defines.svh -----
// Assertion macros used by the aligned-read filter top level.
// Depends on nothing; files that assert include it and provide aclk and aresetn.
`ifndef ALIGNED_READ_FILTER_EXTEND_STATS_TOP_DEFINES_SVH
`define ALIGNED_READ_FILTER_EXTEND_STATS_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is applied.
`define ARFES_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is applied.
`define ARFES_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/arfes_pkg.sv -----
// Package for the aligned-read filter: sizes, flag bit positions, register codes
// and the word types of the input, result, configuration and screening paths.
// Depends on nothing.
package arfes_pkg;

    localparam int FLAG_KINDS  = 2048;
    localparam int FLAG_BITS   = 11;
    localparam int TALLY_WIDTH = 40;

    localparam int SLOT_W      = $clog2(FLAG_KINDS);
    localparam int OUT_TALLY_W = 40;
    localparam int POS_W       = 31;
    localparam int ISIZE_W     = 32;
    localparam int LEN_W       = 20;
    localparam int SUM_W       = 34;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 3;

    localparam int FL_PAIRED        = 0;
    localparam int FL_PROPER        = 1;
    localparam int FL_MATE_UNMAPPED = 3;
    localparam int FL_REVERSE       = 4;
    localparam int FL_QCFAIL        = 9;
    localparam int FL_DUP           = 10;

    localparam int INC_ZL = 0;
    localparam int INC_ZR = 1;
    localparam int INC_ZE = 2;

    localparam logic [1:0] STRAND_ANY   = 2'd0;
    localparam logic [1:0] STRAND_PLUS  = 2'd1;
    localparam logic [1:0] STRAND_MINUS = 2'd2;

    localparam logic [1:0] RG_WHITE = 2'd1;
    localparam logic [1:0] RG_BLACK = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAIRING_MODE  = 3'd0,
        CFG_INCLUDE_MASK  = 3'd1,
        CFG_MIN_MAPQ      = 3'd2,
        CFG_MAX_DUPES     = 3'd3,
        CFG_STRAND_SELECT = 3'd4,
        CFG_EXTEND_LENGTH = 3'd5,
        CFG_RG_MODE       = 3'd6,
        CFG_CHROM_SIZE    = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [10:0]              read_flag;
        logic [POS_W-1:0]         read_pos;
        logic signed [ISIZE_W-1:0] insert_size;
        logic [POS_W-1:0]         align_end;
        logic [7:0]               map_quality;
        logic                     has_zl;
        logic                     has_zr;
        logic                     has_ze;
        logic                     has_zd;
        logic [15:0]              dupe_number;
        logic                     has_group;
        logic                     group_listed;
    } arfes_in_t;

    typedef struct packed {
        logic                   accepted;
        logic [POS_W-1:0]       frag_start;
        logic [POS_W-1:0]       frag_end;
        logic                   minus_strand;
        logic [OUT_TALLY_W-1:0] flag_tally;
    } arfes_out_t;

    typedef struct packed {
        logic [1:0]       pairing_mode;
        logic [3:0]       include_mask;
        logic [7:0]       min_mapq;
        logic [15:0]      max_dupes;
        logic [1:0]       strand_select;
        logic [LEN_W-1:0] extend_length;
        logic [1:0]       rg_mode;
        logic [POS_W-1:0] chrom_size;
    } arfes_cfg_t;

    // Screening result: start = start_a + start_b, end = end_a + end_b.
    typedef struct packed {
        logic                    keep;
        logic                    check_order;
        logic                    minus;
        logic signed [SUM_W-1:0] start_a;
        logic signed [SUM_W-1:0] start_b;
        logic signed [SUM_W-1:0] end_a;
        logic signed [SUM_W-1:0] end_b;
    } arfes_screen_t;

endpackage

// ----- hw/rtl/arfes_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// Read returns the old contents when the same entry is written in that cycle.
module arfes_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/arfes_screen.sv -----
// Read screening: filter rules, strand choice and fragment operand selection.
// Depends on arfes_pkg; purely combinational, registered by the top level.
module arfes_screen (
    input  arfes_pkg::arfes_in_t     in_word,
    input  arfes_pkg::arfes_cfg_t    cfg,
    output arfes_pkg::arfes_screen_t scr
);
    import arfes_pkg::*;

    logic                    paired, proper, mate_unmapped, rev, qcfail, dup;
    logic                    reject, single, strand_ok, len_pos, isize_pos;
    logic signed [SUM_W-1:0] pos_x, aend_x, isize_x, len_x, zero_x;
    logic signed [SUM_W-1:0] half_len_x, rest_len_x, mid_x;
    logic [LEN_W-1:0]        rest_len;

    always_comb begin
        paired        = in_word.read_flag[FL_PAIRED];
        proper        = in_word.read_flag[FL_PROPER];
        mate_unmapped = in_word.read_flag[FL_MATE_UNMAPPED];
        rev           = in_word.read_flag[FL_REVERSE];
        qcfail        = in_word.read_flag[FL_QCFAIL];
        dup           = in_word.read_flag[FL_DUP];

        reject = 1'b0;
        if (cfg.pairing_mode[0] && !proper) begin
            reject = 1'b1;
        end
        if (cfg.pairing_mode[1] && proper) begin
            reject = 1'b1;
        end
        if (qcfail) begin
            if (cfg.include_mask == 4'd0) begin
                reject = 1'b1;
            end
            if (!cfg.include_mask[INC_ZL] && in_word.has_zl) begin
                reject = 1'b1;
            end
            if (!cfg.include_mask[INC_ZR] && in_word.has_zr) begin
                reject = 1'b1;
            end
            if (!cfg.include_mask[INC_ZE] && in_word.has_ze) begin
                reject = 1'b1;
            end
            if (cfg.min_mapq != 8'd0 && in_word.map_quality < cfg.min_mapq) begin
                reject = 1'b1;
            end
        end
        if (dup) begin
            if (cfg.max_dupes <= 16'd1) begin
                reject = 1'b1;
            end
            if (in_word.has_zd && in_word.dupe_number > cfg.max_dupes) begin
                reject = 1'b1;
            end
        end
        if (in_word.has_group) begin
            if (cfg.rg_mode == RG_WHITE && !in_word.group_listed) begin
                reject = 1'b1;
            end
            if (cfg.rg_mode == RG_BLACK && in_word.group_listed) begin
                reject = 1'b1;
            end
        end

        case (cfg.strand_select)
            STRAND_ANY:   strand_ok = 1'b1;
            STRAND_PLUS:  strand_ok = !rev;
            STRAND_MINUS: strand_ok = rev;
            default:      strand_ok = 1'b0;
        endcase

        single    = !paired || mate_unmapped;
        len_pos   = cfg.extend_length != '0;
        isize_pos = !in_word.insert_size[ISIZE_W-1] && in_word.insert_size != '0;

        zero_x     = '0;
        pos_x      = {{(SUM_W-POS_W){1'b0}}, in_word.read_pos};
        aend_x     = {{(SUM_W-POS_W){1'b0}}, in_word.align_end};
        isize_x    = {{(SUM_W-ISIZE_W){in_word.insert_size[ISIZE_W-1]}}, in_word.insert_size};
        len_x      = {{(SUM_W-LEN_W){1'b0}}, cfg.extend_length};
        half_len_x = {{(SUM_W-LEN_W+1){1'b0}}, cfg.extend_length[LEN_W-1:1]};
        rest_len   = cfg.extend_length - {1'b0, cfg.extend_length[LEN_W-1:1]};
        rest_len_x = {{(SUM_W-LEN_W){1'b0}}, rest_len};
        // Pair midpoint; the template length is positive whenever it is used.
        mid_x      = pos_x + (isize_x >>> 1);

        scr.keep        = !reject && (single ? strand_ok : (proper && isize_pos));
        scr.check_order = single;
        scr.minus       = single && rev;

        if (single && !rev) begin
            scr.start_a = pos_x;
            scr.start_b = zero_x;
            if (len_pos) begin
                scr.end_a = pos_x;
                scr.end_b = len_x;
            end else if (isize_pos) begin
                scr.end_a = pos_x;
                scr.end_b = isize_x;
            end else begin
                scr.end_a = aend_x;
                scr.end_b = zero_x;
            end
        end else if (single) begin
            scr.end_a = aend_x;
            scr.end_b = zero_x;
            if (len_pos) begin
                scr.start_a = aend_x;
                scr.start_b = -len_x;
            end else if (isize_pos) begin
                scr.start_a = aend_x;
                scr.start_b = -isize_x;
            end else begin
                scr.start_a = pos_x;
                scr.start_b = zero_x;
            end
        end else if (len_pos) begin
            // Fixed length centered on the pair midpoint.
            scr.start_a = mid_x;
            scr.start_b = -half_len_x;
            scr.end_a   = mid_x;
            scr.end_b   = rest_len_x;
        end else begin
            scr.start_a = pos_x;
            scr.start_b = zero_x;
            scr.end_a   = pos_x;
            scr.end_b   = isize_x;
        end
    end

endmodule

// ----- hw/rtl/aligned_read_filter_extend_stats_top.sv -----
// Aligned-read filter, fragment builder and flag statistics: top level.
// An accepted word passes the stage 1, 2 and 3 registers, then the output register.
// Throughput: one word per cycle while m_ready and the reset sweep allow it.
// Reset clears configuration and bit tallies, then sweeps the histogram RAM to
// zero slot by slot, during which s_ready is low (configuration is still taken).
// Depends on arfes_pkg, arfes_ram, arfes_screen and the assertion macro header.
`include "aligned_read_filter_extend_stats_top_defines.svh"

module aligned_read_filter_extend_stats_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  arfes_pkg::arfes_in_t                  s_word,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output arfes_pkg::arfes_out_t                 m_word,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [arfes_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [arfes_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import arfes_pkg::*;

    // Configuration registers. Writes are always taken; software must write them
    // only while the pipeline is empty; the block itself does not enforce this.
    arfes_cfg_t cfg_reg;

    // Histogram clearing sweep after reset.
    logic              clearing_reg;
    logic [SLOT_W-1:0] clr_addr_reg;

    // Stage 1: accepted input word.
    logic      s1_valid_reg;
    arfes_in_t s1_word_reg;

    // Stage 2: screened word with fragment operands.
    logic          s2_valid_reg;
    arfes_screen_t s2_scr_reg;
    logic [10:0]   s2_flag_reg;

    // Stage 3: final decision; the histogram read data lines up with this stage.
    logic             s3_valid_reg;
    logic             s3_ok_reg;
    logic [POS_W-1:0] s3_start_reg;
    logic [POS_W-1:0] s3_end_reg;
    logic             s3_minus_reg;
    logic [10:0]      s3_flag_reg;

    // Output register.
    logic       m_valid_reg;
    arfes_out_t m_word_reg;

    // Most recent histogram write, forwarded to a read that raced it.
    logic                   lw_valid_reg;
    logic [SLOT_W-1:0]      lw_slot_reg;
    logic [TALLY_WIDTH-1:0] lw_data_reg;

    logic [TALLY_WIDTH-1:0] bit_tally_reg [FLAG_BITS];

    arfes_screen_t          scr;
    logic                   adv1, adv2, adv3, s2_free, s3_free, out_free;
    logic signed [SUM_W-1:0] start_x, end_x, limit_x;
    logic                   s2_ok;
    logic [SLOT_W-1:0]      s2_slot, s3_slot;
    logic [TALLY_WIDTH-1:0] ram_rdata, tally_cur, tally_next;
    logic                   ram_we;
    logic [SLOT_W-1:0]      ram_waddr;
    logic [TALLY_WIDTH-1:0] ram_wdata;
    logic [FLAG_BITS-1:0]   s3_flag_ext;

    // Stall chain: each stage moves when the one after it is empty or moving.
    assign out_free  = !m_valid_reg || m_ready;
    assign adv3      = s3_valid_reg && out_free;
    assign s3_free   = !s3_valid_reg || adv3;
    assign adv2      = s2_valid_reg && s3_free;
    assign s2_free   = !s2_valid_reg || adv2;
    assign adv1      = s1_valid_reg && s2_free;
    assign s_ready   = !clearing_reg && (!s1_valid_reg || adv1);
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index_t'(cfg_index))
                CFG_PAIRING_MODE:  cfg_reg.pairing_mode  <= cfg_data[1:0];
                CFG_INCLUDE_MASK:  cfg_reg.include_mask  <= cfg_data[3:0];
                CFG_MIN_MAPQ:      cfg_reg.min_mapq      <= cfg_data[7:0];
                CFG_MAX_DUPES:     cfg_reg.max_dupes     <= cfg_data[15:0];
                CFG_STRAND_SELECT: cfg_reg.strand_select <= cfg_data[1:0];
                CFG_EXTEND_LENGTH: cfg_reg.extend_length <= cfg_data[LEN_W-1:0];
                CFG_RG_MODE:       cfg_reg.rg_mode       <= cfg_data[1:0];
                CFG_CHROM_SIZE:    cfg_reg.chrom_size    <= cfg_data[POS_W-1:0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // The sweep writes one zero entry per cycle until the last slot is done.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clearing_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == SLOT_W'(FLAG_KINDS - 1)) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // Stage 1 screening: filter rules and the operands of the fragment sums.
    arfes_screen u_screen (
        .in_word (s1_word_reg),
        .cfg     (cfg_reg),
        .scr     (scr)
    );

    // Stage 2: one add per bound, then the bounds compare. The start-before-end
    // check applies to single reads only; pairs are ordered by construction.
    assign start_x = s2_scr_reg.start_a + s2_scr_reg.start_b;
    assign end_x   = s2_scr_reg.end_a + s2_scr_reg.end_b;
    assign limit_x = {{(SUM_W-POS_W){1'b0}}, cfg_reg.chrom_size};
    assign s2_ok   = s2_scr_reg.keep
                     && !(s2_scr_reg.check_order && start_x >= end_x)
                     && !start_x[SUM_W-1]
                     && !(end_x > limit_x);
    assign s2_slot = SLOT_W'(s2_flag_reg);
    assign s3_slot = SLOT_W'(s3_flag_reg);

    // Stage 3: the read issued when the word entered this stage may have missed
    // the write made in that same cycle, so the last write is forwarded.
    assign tally_cur   = (lw_valid_reg && lw_slot_reg == s3_slot) ? lw_data_reg : ram_rdata;
    assign tally_next  = tally_cur + TALLY_WIDTH'(s3_ok_reg);
    assign s3_flag_ext = FLAG_BITS'(s3_flag_reg);

    assign ram_we    = clearing_reg || (adv3 && s3_ok_reg);
    assign ram_waddr = clearing_reg ? clr_addr_reg : s3_slot;
    assign ram_wdata = clearing_reg ? '0 : tally_next;

    arfes_ram #(
        .WIDTH (TALLY_WIDTH),
        .DEPTH (FLAG_KINDS)
    ) u_hist_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (adv2),
        .rd_addr (s2_slot),
        .rd_data (ram_rdata)
    );

    // Valid bits of the pipeline and the forwarding entry.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            lw_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                s1_valid_reg <= 1'b1;
            end else if (adv1) begin
                s1_valid_reg <= 1'b0;
            end
            if (adv1) begin
                s2_valid_reg <= 1'b1;
            end else if (adv2) begin
                s2_valid_reg <= 1'b0;
            end
            if (adv2) begin
                s3_valid_reg <= 1'b1;
            end else if (adv3) begin
                s3_valid_reg <= 1'b0;
            end
            if (adv3) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (!clearing_reg && ram_we) begin
                lw_valid_reg <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            s1_word_reg <= s_word;
        end
        if (adv1) begin
            s2_scr_reg  <= scr;
            s2_flag_reg <= s1_word_reg.read_flag;
        end
        if (adv2) begin
            s3_ok_reg    <= s2_ok;
            s3_start_reg <= s2_ok ? start_x[POS_W-1:0] : '0;
            s3_end_reg   <= s2_ok ? end_x[POS_W-1:0] : '0;
            s3_minus_reg <= s2_ok && s2_scr_reg.minus;
            s3_flag_reg  <= s2_flag_reg;
        end
        if (adv3) begin
            m_word_reg.accepted     <= s3_ok_reg;
            m_word_reg.frag_start   <= s3_start_reg;
            m_word_reg.frag_end     <= s3_end_reg;
            m_word_reg.minus_strand <= s3_minus_reg;
            m_word_reg.flag_tally   <= OUT_TALLY_W'(tally_next);
        end
        if (!clearing_reg && ram_we) begin
            lw_slot_reg <= ram_waddr;
            lw_data_reg <= ram_wdata;
        end
    end

    // One counter per flag bit, bumped for every accepted read with that bit set.
    always_ff @(posedge aclk) begin
        for (int b = 0; b < FLAG_BITS; b++) begin
            if (!aresetn) begin
                bit_tally_reg[b] <= '0;
            end else if (adv3 && s3_ok_reg && s3_flag_ext[b]) begin
                bit_tally_reg[b] <= bit_tally_reg[b] + 1'b1;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

    `ARFES_ASSERT_IMPL(a_clear_pipe_empty, clearing_reg, !s1_valid_reg && !s2_valid_reg && !s3_valid_reg, "word in pipeline during histogram clear")
    `ARFES_ASSERT_NEXT(a_out_load, adv3, m_valid_reg, "stage 3 word lost on its way out")
    `ARFES_ASSERT_IMPL(a_reject_zero, m_valid_reg && !m_word_reg.accepted, m_word_reg.frag_start == '0 && m_word_reg.frag_end == '0 && !m_word_reg.minus_strand, "rejected word carries a fragment")
    `ARFES_ASSERT_IMPL(a_frag_order, m_valid_reg && m_word_reg.accepted, m_word_reg.frag_start < m_word_reg.frag_end, "accepted fragment is empty")

endmodule

// ----- verif/fragment_checker.sv -----
// Scoreboard for the aligned-read filter: mirrors the register file, the flag
// histogram and the fragment rules, and compares every result word in order.
// Depends on arfes_pkg only.
module fragment_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  arfes_pkg::arfes_in_t             s_word,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  arfes_pkg::arfes_out_t            m_word,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [arfes_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [arfes_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                               fail_count,
    output int                               outstanding,
    output int                               reads_seen,
    output int                               frags_seen
);
    import arfes_pkg::*;

    arfes_cfg_t             cfg_shadow;
    logic [TALLY_WIDTH-1:0] flag_counts [FLAG_KINDS];
    arfes_out_t             expected_frags [$];
    int                     errors = 0;

    // The per-bit tallies are not visible on the result word, so only the
    // histogram is mirrored here.

    function automatic bit filtered_out(arfes_in_t rd);
        logic proper;
        proper = rd.read_flag[FL_PROPER];
        if (cfg_shadow.pairing_mode[0] && !proper) return 1'b1;
        if (cfg_shadow.pairing_mode[1] && proper) return 1'b1;
        if (rd.read_flag[FL_QCFAIL]) begin
            if (cfg_shadow.include_mask == 4'd0) return 1'b1;
            if (!cfg_shadow.include_mask[INC_ZL] && rd.has_zl) return 1'b1;
            if (!cfg_shadow.include_mask[INC_ZR] && rd.has_zr) return 1'b1;
            if (!cfg_shadow.include_mask[INC_ZE] && rd.has_ze) return 1'b1;
            if (cfg_shadow.min_mapq != 8'd0 && rd.map_quality < cfg_shadow.min_mapq)
                return 1'b1;
        end
        if (rd.read_flag[FL_DUP]) begin
            if (cfg_shadow.max_dupes <= 16'd1) return 1'b1;
            if (rd.has_zd && rd.dupe_number > cfg_shadow.max_dupes) return 1'b1;
        end
        if (rd.has_group) begin
            if (cfg_shadow.rg_mode == RG_WHITE && !rd.group_listed) return 1'b1;
            if (cfg_shadow.rg_mode == RG_BLACK && rd.group_listed) return 1'b1;
        end
        return 1'b0;
    endfunction

    // Builds the fragment of one read and bumps the histogram when it is kept.
    // All interval arithmetic is done in 64 bits so nothing wraps.
    function automatic arfes_out_t predict_fragment(arfes_in_t rd);
        arfes_out_t        res;
        longint            pos, isize, aend, len, limit, lo, hi, mid;
        bit                ok, minus, rev;
        logic [SLOT_W-1:0] slot;
        pos   = longint'(rd.read_pos);
        isize = longint'($signed(rd.insert_size));
        aend  = longint'(rd.align_end);
        len   = longint'(cfg_shadow.extend_length);
        limit = longint'(cfg_shadow.chrom_size);
        rev   = rd.read_flag[FL_REVERSE];
        lo    = 0;
        hi    = 0;
        ok    = 1'b0;
        minus = 1'b0;
        res   = '0;
        if (!filtered_out(rd)) begin
            if (!rd.read_flag[FL_PAIRED] || rd.read_flag[FL_MATE_UNMAPPED]) begin
                if (cfg_shadow.strand_select == STRAND_ANY ||
                    (cfg_shadow.strand_select == STRAND_PLUS && !rev) ||
                    (cfg_shadow.strand_select == STRAND_MINUS && rev)) begin
                    if (!rev) begin
                        lo = pos;
                        hi = (len > 0) ? lo + len : (isize > 0) ? lo + isize : aend;
                    end else begin
                        hi = aend;
                        lo = (len > 0) ? hi - len : (isize > 0) ? hi - isize : pos;
                    end
                    ok    = !(lo >= hi || lo < 0 || hi > limit);
                    minus = rev;
                end
            end else if (rd.read_flag[FL_PROPER] && isize > 0) begin
                mid = pos + isize / 2;
                lo  = pos;
                hi  = pos + isize;
                if (len > 0) begin
                    lo = mid - len / 2;
                    hi = lo + len;
                end
                ok = !(lo < 0 || hi > limit);
            end
        end
        slot = rd.read_flag[SLOT_W-1:0];
        if (ok) begin
            flag_counts[slot]  = flag_counts[slot] + 1'b1;
            res.accepted       = 1'b1;
            res.frag_start     = lo[POS_W-1:0];
            res.frag_end       = hi[POS_W-1:0];
            res.minus_strand   = minus;
        end
        res.flag_tally = OUT_TALLY_W'(flag_counts[slot]);
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] want, logic [63:0] got);
        $error("%s mismatch: expected %0d, actual %0d", field, want, got);
        errors++;
    endtask

    always @(posedge aclk) begin
        arfes_out_t want;
        if (!aresetn) begin
            cfg_shadow = '0;
            foreach (flag_counts[i]) flag_counts[i] = '0;
            expected_frags.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index_t'(cfg_index))
                    CFG_PAIRING_MODE:  cfg_shadow.pairing_mode  = cfg_data[1:0];
                    CFG_INCLUDE_MASK:  cfg_shadow.include_mask  = cfg_data[3:0];
                    CFG_MIN_MAPQ:      cfg_shadow.min_mapq      = cfg_data[7:0];
                    CFG_MAX_DUPES:     cfg_shadow.max_dupes     = cfg_data[15:0];
                    CFG_STRAND_SELECT: cfg_shadow.strand_select = cfg_data[1:0];
                    CFG_EXTEND_LENGTH: cfg_shadow.extend_length = cfg_data[LEN_W-1:0];
                    CFG_RG_MODE:       cfg_shadow.rg_mode       = cfg_data[1:0];
                    CFG_CHROM_SIZE:    cfg_shadow.chrom_size    = cfg_data[POS_W-1:0];
                    default: ;
                endcase
            end
            // Results are retired before new reads are queued, since a result can
            // never belong to a read taken at the same edge.
            if (m_valid && m_ready) begin
                if (expected_frags.size() == 0) begin
                    $error("result word with no read waiting: %p", m_word);
                    errors++;
                end else begin
                    want = expected_frags.pop_front();
                    if (m_word.accepted !== want.accepted)
                        report_mismatch("accepted", want.accepted, m_word.accepted);
                    if (m_word.frag_start !== want.frag_start)
                        report_mismatch("frag_start", want.frag_start, m_word.frag_start);
                    if (m_word.frag_end !== want.frag_end)
                        report_mismatch("frag_end", want.frag_end, m_word.frag_end);
                    if (m_word.minus_strand !== want.minus_strand)
                        report_mismatch("minus_strand", want.minus_strand,
                                        m_word.minus_strand);
                    if (m_word.flag_tally !== want.flag_tally)
                        report_mismatch("flag_tally", want.flag_tally, m_word.flag_tally);
                    if (want.accepted) frags_seen <= frags_seen + 1;
                end
            end
            if (s_valid && s_ready) begin
                expected_frags.push_back(predict_fragment(s_word));
                reads_seen <= reads_seen + 1;
            end
        end
        outstanding <= expected_frags.size();
        fail_count  <= errors;
    end

endmodule

// ----- verif/tb_top.sv -----
// Top of the aligned-read filter testbench: clock, reset, register writes,
// read stimulus, result back-pressure and the final verdict.
// Depends on arfes_pkg, the filter top level and fragment_checker.
module tb_top;
    import arfes_pkg::*;

    // Flag masks built from the package bit positions.
    localparam logic [10:0] PAIRED        = 11'd1 << FL_PAIRED;
    localparam logic [10:0] PROPER        = 11'd1 << FL_PROPER;
    localparam logic [10:0] MATE_UNMAPPED = 11'd1 << FL_MATE_UNMAPPED;
    localparam logic [10:0] REVERSE       = 11'd1 << FL_REVERSE;
    localparam logic [10:0] QCFAIL        = 11'd1 << FL_QCFAIL;
    localparam logic [10:0] DUP           = 11'd1 << FL_DUP;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    // A clean run, the histogram sweep after reset included, stays far below
    // this limit, so it only trips on a hang.
    localparam int CYCLE_LIMIT = 300000;

    localparam int READS_PER_SETTING = 50;
    localparam int SETTINGS_PER_PHASE = 3;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    arfes_in_t             s_word    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    arfes_out_t            m_word;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int fail_count;
    int outstanding;
    int reads_seen;
    int frags_seen;

    // Percentages of cycles in which the sender holds back a word and the
    // receiver refuses one. They are changed only between phases.
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int          settings_applied = 0;
    int          cycle_count      = 0;

    always #6 aclk = ~aclk;

    aligned_read_filter_extend_stats_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    fragment_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_word      (s_word),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_word      (m_word),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .reads_seen  (reads_seen),
        .frags_seen  (frags_seen)
    );

    // The receiver draws a fresh ready every cycle; with stall_pct at zero it
    // simply takes every result word as it comes.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: a stuck handshake ends the run here instead of hanging it.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $error("no progress after %0d cycles, %0d results still owed",
                   CYCLE_LIMIT, outstanding);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Presents one register write and holds it until the block takes it. The
    // valid is left high so back-to-back writes never drop it between words.
    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Writes the whole register file; every setting touches every register.
    task automatic apply_settings(arfes_cfg_t c);
        write_reg(CFG_PAIRING_MODE,  CFG_DATA_W'(c.pairing_mode));
        write_reg(CFG_INCLUDE_MASK,  CFG_DATA_W'(c.include_mask));
        write_reg(CFG_MIN_MAPQ,      CFG_DATA_W'(c.min_mapq));
        write_reg(CFG_MAX_DUPES,     CFG_DATA_W'(c.max_dupes));
        write_reg(CFG_STRAND_SELECT, CFG_DATA_W'(c.strand_select));
        write_reg(CFG_EXTEND_LENGTH, CFG_DATA_W'(c.extend_length));
        write_reg(CFG_RG_MODE,       CFG_DATA_W'(c.rg_mode));
        write_reg(CFG_CHROM_SIZE,    CFG_DATA_W'(c.chrom_size));
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    // Sends one read word. Idle cycles are inserted before the word at random,
    // so gaps land in front of every stage of the pipeline.
    task automatic send_read(arfes_in_t rd);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= rd;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drops the input valid and waits until every predicted result has been
    // taken. The first edge is always waited out so that the read accepted at
    // the current edge is already counted by the checker.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    function automatic arfes_in_t make_read(logic [10:0] flag, logic [POS_W-1:0] pos,
                                            logic signed [ISIZE_W-1:0] isize,
                                            logic [POS_W-1:0] aend);
        arfes_in_t rd;
        rd             = '0;
        rd.read_flag   = flag;
        rd.read_pos    = pos;
        rd.insert_size = isize;
        rd.align_end   = aend;
        return rd;
    endfunction

    // Random register file with the extremes of the mapping-quality, duplicate,
    // extension-length and chromosome-size registers drawn often. Most settings leave
    // the pairing filter open so that reads reach the fragment builder and the histogram.
    function automatic arfes_cfg_t random_settings();
        arfes_cfg_t c;
        c.pairing_mode = ($urandom_range(3) == 0) ? 2'($urandom_range(3, 1)) : 2'd0;
        c.include_mask = 4'($urandom_range(15));
        case ($urandom_range(3))
            0:       c.min_mapq = 8'd0;
            1:       c.min_mapq = 8'd255;
            default: c.min_mapq = 8'($urandom_range(255));
        endcase
        case ($urandom_range(3))
            0:       c.max_dupes = 16'd0;
            1:       c.max_dupes = 16'd1;
            2:       c.max_dupes = 16'hFFFF;
            default: c.max_dupes = 16'($urandom_range(40, 2));
        endcase
        c.strand_select = ($urandom_range(7) == 0) ? 2'd3 : 2'($urandom_range(2));
        case ($urandom_range(3))
            0:       c.extend_length = '1;
            1:       c.extend_length = LEN_W'($urandom_range(800, 1));
            default: c.extend_length = '0;
        endcase
        c.rg_mode = 2'($urandom_range(3));
        case ($urandom_range(3))
            0:       c.chrom_size = POS_MAX;
            1:       c.chrom_size = POS_W'($urandom_range(32'h7FFF_FFFF, 1));
            default: c.chrom_size = POS_W'($urandom_range(2000000, 2000));
        endcase
        return c;
    endfunction

    // One read of random content. A tenth are pure noise over every bit of every
    // field; the rest are shaped reads of one of four kinds (single, mate
    // unmapped, proper pair, improper pair) placed inside the chromosome with a
    // plausible insert size and alignment end, so most of them reach the
    // fragment rules rather than dying on a bound.
    function automatic arfes_in_t random_read(logic [POS_W-1:0] chrom);
        arfes_in_t   rd;
        int          frag_len;
        logic [10:0] flag;
        rd.read_flag    = 11'($urandom);
        rd.read_pos     = POS_W'($urandom);
        rd.insert_size  = $urandom;
        rd.align_end    = POS_W'($urandom);
        rd.map_quality  = 8'($urandom);
        rd.has_zl       = 1'($urandom);
        rd.has_zr       = 1'($urandom);
        rd.has_ze       = 1'($urandom);
        rd.has_zd       = 1'($urandom);
        rd.dupe_number  = 16'($urandom);
        rd.has_group    = 1'($urandom);
        rd.group_listed = 1'($urandom);
        if ($urandom_range(99) >= 10) begin
            flag = rd.read_flag;
            case ($urandom_range(3))
                0: flag[FL_PAIRED] = 1'b0;
                1: begin
                    flag[FL_PAIRED]        = 1'b1;
                    flag[FL_MATE_UNMAPPED] = 1'b1;
                end
                2: begin
                    flag[FL_PAIRED]        = 1'b1;
                    flag[FL_PROPER]        = 1'b1;
                    flag[FL_MATE_UNMAPPED] = 1'b0;
                end
                default: begin
                    flag[FL_PAIRED]        = 1'b1;
                    flag[FL_PROPER]        = 1'b0;
                    flag[FL_MATE_UNMAPPED] = 1'b0;
                end
            endcase
            flag[FL_QCFAIL] = ($urandom_range(99) < 15);
            flag[FL_DUP]    = ($urandom_range(99) < 15);
            rd.read_flag    = flag;
            rd.read_pos     = POS_W'($urandom_range(chrom));
            frag_len        = $urandom_range(600, 1);
            case ($urandom_range(9))
                0:       rd.insert_size = -frag_len;
                1:       rd.insert_size = '0;
                default: rd.insert_size = frag_len;
            endcase
            rd.align_end = rd.read_pos + POS_W'($urandom_range(300, 1));
            rd.has_zl    = ($urandom_range(4) == 0);
            rd.has_zr    = ($urandom_range(4) == 0);
            rd.has_ze    = ($urandom_range(4) == 0);
            if ($urandom_range(1)) rd.dupe_number = 16'($urandom_range(5));
        end
        return rd;
    endfunction

    initial begin
        arfes_in_t  rd;
        arfes_cfg_t setting;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, first setting: every filter open and the chromosome as
        // long as the field allows. The registers are taken during the
        // histogram sweep; the first read waits for s_ready.
        apply_settings('{pairing_mode: 2'd0, include_mask: 4'hF, min_mapq: 8'd0,
                         max_dupes: 16'hFFFF, strand_select: STRAND_ANY,
                         extend_length: '0, rg_mode: 2'd0, chrom_size: POS_MAX});
        // Single reads: forward with a positive insert, forward falling back to
        // the alignment end, reverse with a positive insert, reverse falling
        // back to the read position, and an empty interval that is dropped.
        send_read(make_read(11'd0, 100, 50, 180));
        send_read(make_read(11'd0, 100, -5, 180));
        send_read(make_read(REVERSE, 100, 60, 200));
        send_read(make_read(REVERSE, 100, 0, 200));
        send_read(make_read(11'd0, 500, 0, 400));
        // Pairs: proper and positive, proper but negative, and not proper.
        send_read(make_read(PAIRED | PROPER, 1000, 301, 1100));
        send_read(make_read(PAIRED | PROPER, 1000, -301, 1100));
        send_read(make_read(PAIRED, 1000, 301, 1100));
        // A paired read whose mate is unmapped goes down the single-read path.
        send_read(make_read(PAIRED | MATE_UNMAPPED | REVERSE, 300, 0, 450));
        // Every field at its top value; the fragment spans the whole chromosome.
        rd = make_read('1, POS_MAX, 32'sh7FFF_FFFF, POS_MAX);
        rd.map_quality  = '1;
        rd.has_zl       = 1'b1;
        rd.has_zr       = 1'b1;
        rd.has_ze       = 1'b1;
        rd.has_zd       = 1'b1;
        rd.dupe_number  = '1;
        rd.has_group    = 1'b1;
        rd.group_listed = 1'b1;
        send_read(rd);
        // Every field at its bottom value, with the most negative insert size.
        send_read(make_read(11'd0, 0, 32'sh8000_0000, 0));
        // A duplicate without its count tag is kept while the allowance exceeds one.
        send_read(make_read(DUP, 10, 20, 40));
        // Another kept read with flag zero moves its histogram entry on.
        send_read(make_read(11'd0, 7, 3, 9));

        // Both pairing bits set rejects everything, whatever else is allowed.
        wait_drained();
        apply_settings('{pairing_mode: 2'd3, include_mask: 4'h0, min_mapq: 8'd255,
                         max_dupes: 16'd1, strand_select: 2'd3, extend_length: '1,
                         rg_mode: 2'd3, chrom_size: '0});
        send_read(make_read(PAIRED | PROPER, 1000, 301, 1100));
        send_read(make_read(11'd0, 100, 50, 180));

        // Proper pairs only, QC-failed reads screened on mapping quality and their tags,
        // fixed-length fragments centred on the pair and a read-group whitelist.
        wait_drained();
        apply_settings('{pairing_mode: 2'd1, include_mask: 4'h8, min_mapq: 8'd30,
                         max_dupes: 16'd2, strand_select: STRAND_PLUS,
                         extend_length: LEN_W'(200), rg_mode: RG_WHITE,
                         chrom_size: POS_W'(5000)});
        send_read(make_read(PAIRED | PROPER, 1000, 300, 1100));
        rd = make_read(PAIRED | PROPER | QCFAIL, 1000, 300, 1100);
        rd.map_quality = 8'd20;
        send_read(rd);
        rd.map_quality = 8'd40;
        rd.has_zl      = 1'b1;
        send_read(rd);
        rd = make_read(PAIRED | PROPER | DUP, 1000, 300, 1100);
        rd.has_zd      = 1'b1;
        rd.dupe_number = 16'd3;
        send_read(rd);
        rd = make_read(PAIRED | PROPER, 1000, 300, 1100);
        rd.has_group = 1'b1;
        send_read(rd);
        // Centred fragments running past the chromosome end and below zero.
        send_read(make_read(PAIRED | PROPER, 4900, 200, 5000));
        send_read(make_read(PAIRED | PROPER, 0, 10, 10));

        // Non-proper reads only, minus strand only and a read-group blacklist.
        wait_drained();
        apply_settings('{pairing_mode: 2'd2, include_mask: 4'h0, min_mapq: 8'd0,
                         max_dupes: 16'd0, strand_select: STRAND_MINUS,
                         extend_length: '0, rg_mode: RG_BLACK,
                         chrom_size: POS_W'(1000)});
        rd = make_read(REVERSE, 100, 0, 200);
        rd.has_group    = 1'b1;
        rd.group_listed = 1'b1;
        send_read(rd);
        rd.group_listed = 1'b0;
        send_read(rd);
        send_read(make_read(11'd0, 100, 0, 200));
        send_read(make_read(REVERSE, 900, 0, 1001));

        // Random part: four handshake patterns, each run under several random
        // register settings. The first pattern never idles on either side.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 82; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 82; end
                default: begin send_idle_pct = 8; stall_pct = 8; end
            endcase
            for (int seg = 0; seg < SETTINGS_PER_PHASE; seg++) begin
                wait_drained();
                setting = random_settings();
                apply_settings(setting);
                repeat (READS_PER_SETTING) send_read(random_read(setting.chrom_size));
            end
        end

        // Wait for the last results, then let the clock run on so that any stray
        // extra word would still be caught.
        wait_drained();
        repeat (12) @(posedge aclk);

        $display("Run covered %0d reads under %0d register settings and four handshake",
                 reads_seen, settings_applied);
        $display("patterns; %0d reads became fragments.", frags_seen);
        if (fail_count == 0 && outstanding == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/arfes_pkg.sv
hw/rtl/arfes_ram.sv
hw/rtl/arfes_screen.sv
hw/rtl/aligned_read_filter_extend_stats_top.sv
verif/fragment_checker.sv
verif/tb_top.sv
